>>> design/i2cram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types, codes and constants for the bus sequencer and its top level.
// ----------------------------------------------------------------------------
package i2cram_pkg;

	// Depth of the write data buffer and the width of a slot index.
	localparam int MAX_WRITE_BYTES = 16;
	localparam int WBUF_AW         = $clog2(MAX_WRITE_BYTES);

	// Register defaults after reset.
	localparam logic [6:0] RESET_SLAVE_ADDRESS = 7'h68;
	localparam logic [7:0] RESET_ACK_TIMEOUT   = 8'd250;

	// Byte with only the most significant bit set.
	localparam logic [7:0] MSB8 = 8'h80;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_SLAVE_ADDRESS = 1'b0,
		CFG_ACK_TIMEOUT   = 1'b1
	} cfg_index_t;

	// Request kinds carried on the input side.
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_LOAD    = 2'd1,
		REQ_START_W = 2'd2,
		REQ_START_R = 2'd3
	} req_t;

	// Bus half-bit phases.
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RS_PREP,
		PH_ST_HIGH,
		PH_ST_LOW,
		PH_TX_LO,
		PH_TX_HI,
		PH_TXACK_LO,
		PH_TXACK_HI,
		PH_RX_LO,
		PH_RX_HI,
		PH_RXACK_LO,
		PH_RXACK_HI,
		PH_SP_LO,
		PH_SP_HI,
		PH_SP_END
	} phase_t;

	// What the byte being shifted out is.
	typedef enum logic [1:0] {
		K_ADDR_W,
		K_REG,
		K_DATA,
		K_ADDR_R
	} kind_t;

	// Sequencer state.
	typedef struct packed {
		phase_t               phase;
		logic [2:0]           bit_count;
		logic [7:0]           bytes_left;
		logic [7:0]           shift_reg;
		logic [7:0]           ack_wait;
		logic [7:0]           latched_reg;
		logic                 is_read;
		logic [WBUF_AW-1:0]   buffer_pos;
		logic                 fail_flag;
		kind_t                tx_kind;
	} seq_state_t;

	// One result item.
	typedef struct packed {
		logic       failed;
		logic       done_res;
		logic       rd_last;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_level;
		logic       scl_level;
	} result_t;

	// Fields of one input item.
	typedef struct packed {
		req_t       req_type;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic       sda_in;
	} step_in_t;

	// Bus configuration seen by the sequencer.
	typedef struct packed {
		logic [6:0] slave_address;
		logic [7:0] ack_timeout_ticks;
	} bus_cfg_t;

endpackage

>>> design/i2cram_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master sequencer step
// Computes the next sequencer state and the bus levels for one tick.
// ----------------------------------------------------------------------------
module i2cram_step import i2cram_pkg::*; (
	input  seq_state_t cur,
	input  step_in_t   req,
	input  bus_cfg_t   cfg,
	input  logic [7:0] buf_byte,
	output seq_state_t nxt,
	output result_t    res
);

	logic acked;
	logic timed_out;

	assign acked     = ~req.sda_in;
	assign timed_out = (cur.ack_wait >= cfg.ack_timeout_ticks);

	always_comb begin
		nxt = cur;
		res = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;
		res.sda_drive = 1'b1;
		res.busy_res  = 1'b1;

		// A start request while idle latches the transfer and runs its first phase now.
		if ((req.req_type == REQ_START_W || req.req_type == REQ_START_R) &&
		    cur.phase == PH_IDLE) begin
			nxt.is_read     = (req.req_type == REQ_START_R);
			nxt.latched_reg = req.reg_addr;
			if (req.req_type == REQ_START_W && req.byte_count > 8'(MAX_WRITE_BYTES)) begin
				nxt.bytes_left = 8'(MAX_WRITE_BYTES);
			end else begin
				nxt.bytes_left = req.byte_count;
			end
			nxt.buffer_pos = '0;
			nxt.fail_flag  = 1'b0;
			nxt.bit_count  = '0;
			nxt.ack_wait   = '0;
			nxt.tx_kind    = K_ADDR_W;
			nxt.phase      = PH_ST_HIGH;
		end

		case (nxt.phase)
			PH_RS_PREP: begin
				res.scl_level = 1'b0;
				nxt.phase     = PH_ST_HIGH;
			end
			PH_ST_HIGH: begin
				nxt.phase = PH_ST_LOW;
			end
			PH_ST_LOW: begin
				res.sda_level = 1'b0;
				nxt.shift_reg = {cfg.slave_address, nxt.tx_kind == K_ADDR_R};
				nxt.bit_count = '0;
				nxt.phase     = PH_TX_LO;
			end
			PH_TX_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = |(nxt.shift_reg & MSB8);
				nxt.phase     = PH_TX_HI;
			end
			PH_TX_HI: begin
				res.sda_level = |(nxt.shift_reg & MSB8);
				nxt.shift_reg = {nxt.shift_reg[6:0], 1'b0};
				nxt.bit_count = nxt.bit_count + 3'd1;
				nxt.phase     = (cur.bit_count == 3'd7) ? PH_TXACK_LO : PH_TX_LO;
			end
			PH_TXACK_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = 1'b0;
				res.sda_drive = 1'b0;
				nxt.ack_wait  = '0;
				nxt.phase     = PH_TXACK_HI;
			end
			PH_TXACK_HI: begin
				res.sda_level = 1'b0;
				res.sda_drive = 1'b0;
				if (!acked && !timed_out) begin
					nxt.ack_wait = cur.ack_wait + 8'd1;
				end else if (!acked && (cur.tx_kind == K_ADDR_W || cur.tx_kind == K_DATA)) begin
					// Missing acknowledge on a checked byte: close with a stop.
					nxt.fail_flag = 1'b1;
					nxt.phase     = PH_SP_LO;
				end else begin
					case (cur.tx_kind)
						K_ADDR_W: begin
							nxt.shift_reg = cur.latched_reg;
							nxt.tx_kind   = K_REG;
							nxt.bit_count = '0;
							nxt.phase     = PH_TX_LO;
						end
						K_REG: begin
							if (cur.is_read) begin
								nxt.tx_kind = K_ADDR_R;
								nxt.phase   = PH_RS_PREP;
							end else if (cur.bytes_left == 8'd0) begin
								nxt.phase = PH_SP_LO;
							end else begin
								nxt.shift_reg = buf_byte;
								nxt.tx_kind   = K_DATA;
								nxt.bit_count = '0;
								nxt.phase     = PH_TX_LO;
							end
						end
						K_DATA: begin
							// Buffer byte was fetched at the following slot.
							nxt.bytes_left = cur.bytes_left - 8'd1;
							nxt.buffer_pos = cur.buffer_pos + 1'b1;
							if (nxt.bytes_left == 8'd0) begin
								nxt.phase = PH_SP_LO;
							end else begin
								nxt.shift_reg = buf_byte;
								nxt.bit_count = '0;
								nxt.phase     = PH_TX_LO;
							end
						end
						default: begin
							if (cur.bytes_left == 8'd0) begin
								nxt.phase = PH_SP_LO;
							end else begin
								nxt.shift_reg = '0;
								nxt.bit_count = '0;
								nxt.phase     = PH_RX_LO;
							end
						end
					endcase
				end
			end
			PH_RX_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = 1'b0;
				res.sda_drive = 1'b0;
				nxt.phase     = PH_RX_HI;
			end
			PH_RX_HI: begin
				res.sda_level = 1'b0;
				res.sda_drive = 1'b0;
				nxt.shift_reg = {cur.shift_reg[6:0], req.sda_in};
				nxt.bit_count = cur.bit_count + 3'd1;
				if (cur.bit_count == 3'd7) begin
					res.rd_valid = 1'b1;
					res.rd_data  = nxt.shift_reg;
					res.rd_last  = (cur.bytes_left == 8'd1);
					nxt.phase    = PH_RXACK_LO;
				end else begin
					nxt.phase = PH_RX_LO;
				end
			end
			PH_RXACK_LO: begin
				// The final byte gets a NACK.
				res.scl_level = 1'b0;
				res.sda_level = (cur.bytes_left == 8'd1);
				nxt.phase     = PH_RXACK_HI;
			end
			PH_RXACK_HI: begin
				res.sda_level  = (cur.bytes_left == 8'd1);
				nxt.bytes_left = cur.bytes_left - 8'd1;
				if (nxt.bytes_left == 8'd0) begin
					nxt.phase = PH_SP_LO;
				end else begin
					nxt.shift_reg = '0;
					nxt.phase     = PH_RX_LO;
				end
			end
			PH_SP_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = 1'b0;
				nxt.phase     = PH_SP_HI;
			end
			PH_SP_HI: begin
				res.sda_level = 1'b0;
				nxt.phase     = PH_SP_END;
			end
			PH_SP_END: begin
				res.done_res = 1'b1;
				res.failed   = cur.fail_flag;
				nxt.phase    = PH_IDLE;
			end
			default: begin
				res.busy_res = 1'b0;
				nxt.phase    = PH_IDLE;
			end
		endcase
	end

endmodule

>>> design/i2c_register_access_master_top.sv
`timescale 1ns / 1ps
// A result item is registered and is valid in the cycle after its input item is taken.
// One item per cycle unless stalled; the sequencer advances one bus half-bit phase per item.
// The output register frees the input side whenever it is empty or being emptied.
// Reset (arst_n low, asynchronous) returns the sequencer to idle, clears the output valid
// and restores slave address 0x68 and acknowledge timeout 250; the write buffer is not cleared.
// ----------------------------------------------------------------------------
// I2C register access master top level
// Register-addressed burst write and read master with a stream interface per tick.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top import i2cram_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	// reg_addr[7:0], byte_count[15:8], wr_index[19:16], wr_byte[27:20], sda_in[28], zero fill
	input  logic [31:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_level[1], sda_drive[2], busy_res[3], rd_data[11:4], rd_valid[12],
	// done_res[13], failed[14], zero fill[15]
	output logic [15:0] m_tdata,
	// rd_last
	output logic        m_tlast
);

	logic               in_acc;
	step_in_t           step_req;
	logic [WBUF_AW-1:0] wr_index;
	logic [7:0]         wr_byte;
	logic               load_req;
	bus_cfg_t           cfg_q;
	seq_state_t         state_q;
	seq_state_t         state_nxt;
	result_t            res_nxt;
	result_t            res_q;
	logic               m_tvalid_q;
	logic [7:0]         wbuf_q [MAX_WRITE_BYTES];
	logic [WBUF_AW-1:0] rd_addr;
	logic [7:0]         buf_byte;

	// Handshake: take a new item unless a result is stalled.
	assign s_tready = ~m_tvalid_q | m_tready;
	assign in_acc   = s_tvalid & s_tready;

	// Unpack the input item.
	assign step_req.req_type   = req_t'(s_tuser);
	assign step_req.reg_addr   = s_tdata[7:0];
	assign step_req.byte_count = s_tdata[15:8];
	assign wr_index            = s_tdata[16 +: WBUF_AW];
	assign wr_byte             = s_tdata[27:20];
	assign step_req.sda_in     = s_tdata[28];
	assign load_req            = in_acc && (step_req.req_type == REQ_LOAD);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address     <= RESET_SLAVE_ADDRESS;
			cfg_q.ack_timeout_ticks <= RESET_ACK_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_addr))
				CFG_SLAVE_ADDRESS: cfg_q.slave_address     <= cfg_wdata[6:0];
				CFG_ACK_TIMEOUT:   cfg_q.ack_timeout_ticks <= cfg_wdata;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Write buffer; a data byte is fetched from the slot after the one just sent.
	always_ff @(posedge clk) begin
		if (load_req) begin
			wbuf_q[wr_index] <= wr_byte;
		end
	end

	assign rd_addr = (state_q.tx_kind == K_DATA) ? state_q.buffer_pos + 1'b1
	                                             : state_q.buffer_pos;

	// A byte loaded in this same item is seen at once.
	assign buf_byte = (load_req && wr_index == rd_addr) ? wr_byte : wbuf_q[rd_addr];

	i2cram_step u_step (
		.cur      (state_q),
		.req      (step_req),
		.cfg      (cfg_q),
		.buf_byte (buf_byte),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// Sequencer state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, tx_kind: K_ADDR_W, default: '0};
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.failed, res_q.done_res, res_q.rd_valid, res_q.rd_data,
	                   res_q.busy_res, res_q.sda_drive, res_q.sda_level, res_q.scl_level};
	assign m_tlast  = res_q.rd_last;

`ifndef SYNTHESIS
	// A finished stop always leaves the sequencer idle.
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res_nxt.done_res) |=> (state_q.phase == PH_IDLE))
		else $error("sequencer not idle after stop");

	// The master never drives SDA while reporting a received byte.
	a_rd_released: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.rd_valid) |-> !res_q.sda_drive)
		else $error("SDA driven during read byte");

	// Failure is only reported together with done.
	a_fail_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.failed) |-> res_q.done_res)
		else $error("failed without done");

	// An idle sequencer stays idle unless a start request arrives.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && state_q.phase == PH_IDLE && s_tuser != REQ_START_W &&
		 s_tuser != REQ_START_R) |=> (state_q.phase == PH_IDLE))
		else $error("sequencer left idle without start");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives request and tick items into the master, plays a simple slave on
// SDA, and compares every result item against a model of the bus sequencer
// or a fixed expectation. Buffer loads and a short directed table come first,
// then random burst writes and reads under two address and timeout settings.
// ----------------------------------------------------------------------------
module tb;
	import i2cram_pkg::*;

	localparam int RAND_ITEMS     = 100;
	localparam int RAND_PHASES    = 2;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int SETTLE_CYCLES  = 3;
	localparam int MAX_REPORTS    = 10;
	localparam int NO_NACK        = -1;

	// How the expectation of a table row is obtained.
	localparam int EXP_PRED  = 0;
	localparam int EXP_IDLE  = 1;
	localparam int EXP_START = 2;

	// One input item.
	typedef struct packed {
		req_t       req;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic [3:0] wr_index;
		logic [7:0] wr_byte;
		logic       sda;
	} stim_t;

	// One result item.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic       busy;
		logic [7:0] rd_data;
		logic       rd_valid;
		logic       rd_last;
		logic       done;
		logic       failed;
	} bus_res_t;

	// A stimulus row: a configuration change, or an item plus the slave behavior
	// for the transfer it may start.
	typedef struct {
		bit         is_cfg;
		logic [6:0] cfg_addr;
		logic [7:0] cfg_limit;
		stim_t      item;
		int         nack_at;
		bit         slow;
		bit         noise;
		int         exp_kind;
	} row_t;

	localparam bus_res_t IDLE_RES = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0,
		rd_data: 8'h00, rd_valid: 1'b0, rd_last: 1'b0, done: 1'b0, failed: 1'b0};
	localparam bus_res_t START_RES = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b1,
		rd_data: 8'h00, rd_valid: 1'b0, rd_last: 1'b0, done: 1'b0, failed: 1'b0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = CFG_SLAVE_ADDRESS;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'h0;
	logic [1:0]  s_tuser = REQ_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	// Sequencer model state and configuration.
	phase_t     ph = PH_IDLE;
	kind_t      tx_kind = K_ADDR_W;
	logic [2:0] bit_cnt = 3'd0;
	logic [7:0] bytes_left = 8'd0;
	logic [7:0] shreg = 8'd0;
	logic [7:0] ack_wait = 8'd0;
	logic [7:0] reg_latch = 8'd0;
	logic       rd_mode = 1'b0;
	logic       fail_flag = 1'b0;
	int         buf_pos = 0;
	logic [6:0] dev_addr = RESET_SLAVE_ADDRESS;
	logic [7:0] ack_limit = RESET_ACK_TIMEOUT;
	logic [7:0] wbuf [MAX_WRITE_BYTES];

	// Slave behavior for the transfer in progress.
	int plan_nack = NO_NACK;
	bit plan_slow = 1'b0;
	bit plan_noise = 1'b0;
	int acks_seen = 0;
	int ack_hold = 0;
	bit src_quiet = 1'b0;

	bus_res_t pending_bus_q [$];
	row_t     dir_rows [$];

	int n_items = 0;
	int n_checked = 0;
	int n_err = 0;
	int n_xfers = 0;
	int n_failed_xfers = 0;
	int n_rd_bytes = 0;
	int n_cfg_writes = 0;
	int idle_cycles = 0;
	int sink_wait = 0;
	bit sink_quiet = 1'b0;

	i2c_register_access_master_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	// Load the next data byte, or close the transfer when none is left.
	function automatic void next_data_byte();
		if (bytes_left == 8'd0) begin
			ph = PH_SP_LO;
		end else begin
			shreg = (buf_pos < MAX_WRITE_BYTES) ? wbuf[buf_pos] : 8'h00;
			tx_kind = K_DATA;
			bit_cnt = 3'd0;
			ph = PH_TX_LO;
		end
	endfunction

	// Leave an acknowledge phase. Only the address+W and data ACKs can fail.
	function automatic void finish_ack(input logic acked);
		if (!acked && (tx_kind == K_ADDR_W || tx_kind == K_DATA)) begin
			fail_flag = 1'b1;
			ph = PH_SP_LO;
		end else begin
			case (tx_kind)
				K_ADDR_W: begin
					shreg = reg_latch;
					tx_kind = K_REG;
					bit_cnt = 3'd0;
					ph = PH_TX_LO;
				end
				K_REG: begin
					if (rd_mode) begin
						tx_kind = K_ADDR_R;
						ph = PH_RS_PREP;
					end else begin
						next_data_byte();
					end
				end
				K_DATA: begin
					bytes_left = bytes_left - 8'd1;
					buf_pos++;
					next_data_byte();
				end
				default: begin
					if (bytes_left == 8'd0) begin
						ph = PH_SP_LO;
					end else begin
						shreg = 8'h00;
						bit_cnt = 3'd0;
						ph = PH_RX_LO;
					end
				end
			endcase
		end
	endfunction

	// Advance the sequencer model by one bus half-bit phase.
	function automatic bus_res_t bus_tick(input stim_t it);
		bus_res_t r;
		logic [7:0] cnt;
		r = IDLE_RES;
		r.busy = 1'b1;
		if (it.req == REQ_LOAD) wbuf[it.wr_index] = it.wr_byte;
		if ((it.req == REQ_START_W || it.req == REQ_START_R) && ph == PH_IDLE) begin
			rd_mode = (it.req == REQ_START_R);
			reg_latch = it.reg_addr;
			cnt = it.byte_count;
			if (!rd_mode && cnt > 8'(MAX_WRITE_BYTES)) cnt = 8'(MAX_WRITE_BYTES);
			bytes_left = cnt;
			buf_pos = 0;
			fail_flag = 1'b0;
			bit_cnt = 3'd0;
			ack_wait = 8'd0;
			tx_kind = K_ADDR_W;
			ph = PH_ST_HIGH;
			n_xfers++;
		end
		case (ph)
			PH_RS_PREP: begin
				r.scl = 1'b0;
				ph = PH_ST_HIGH;
			end
			PH_ST_HIGH: ph = PH_ST_LOW;
			PH_ST_LOW: begin
				r.sda = 1'b0;
				shreg = {dev_addr, tx_kind == K_ADDR_R};
				bit_cnt = 3'd0;
				ph = PH_TX_LO;
			end
			PH_TX_LO: begin
				r.scl = 1'b0;
				r.sda = shreg[7];
				ph = PH_TX_HI;
			end
			PH_TX_HI: begin
				r.sda = shreg[7];
				shreg = {shreg[6:0], 1'b0};
				if (bit_cnt == 3'd7) begin
					bit_cnt = 3'd0;
					ph = PH_TXACK_LO;
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					ph = PH_TX_LO;
				end
			end
			PH_TXACK_LO: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
				r.drive = 1'b0;
				ack_wait = 8'd0;
				ph = PH_TXACK_HI;
			end
			PH_TXACK_HI: begin
				r.sda = 1'b0;
				r.drive = 1'b0;
				if (!it.sda) finish_ack(1'b1);
				else if (ack_wait >= ack_limit) finish_ack(1'b0);
				else ack_wait = ack_wait + 8'd1;
			end
			PH_RX_LO: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
				r.drive = 1'b0;
				ph = PH_RX_HI;
			end
			PH_RX_HI: begin
				r.sda = 1'b0;
				r.drive = 1'b0;
				shreg = {shreg[6:0], it.sda};
				if (bit_cnt == 3'd7) begin
					bit_cnt = 3'd0;
					r.rd_valid = 1'b1;
					r.rd_data = shreg;
					r.rd_last = (bytes_left == 8'd1);
					ph = PH_RXACK_LO;
				end else begin
					bit_cnt = bit_cnt + 3'd1;
					ph = PH_RX_LO;
				end
			end
			PH_RXACK_LO: begin
				r.scl = 1'b0;
				r.sda = (bytes_left == 8'd1);
				ph = PH_RXACK_HI;
			end
			PH_RXACK_HI: begin
				r.sda = (bytes_left == 8'd1);
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0) begin
					ph = PH_SP_LO;
				end else begin
					shreg = 8'h00;
					ph = PH_RX_LO;
				end
			end
			PH_SP_LO: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
				ph = PH_SP_HI;
			end
			PH_SP_HI: begin
				r.sda = 1'b0;
				ph = PH_SP_END;
			end
			PH_SP_END: begin
				r.done = 1'b1;
				r.failed = fail_flag;
				ph = PH_IDLE;
			end
			default: begin
				r.busy = 1'b0;
				ph = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	function automatic string show(input bus_res_t r);
		return $sformatf("scl %b sda %b drv %b busy %b data %h valid %b last %b done %b fail %b",
			r.scl, r.sda, r.drive, r.busy, r.rd_data, r.rd_valid, r.rd_last, r.done, r.failed);
	endfunction

	function automatic stim_t rand_item();
		stim_t it;
		it.req = REQ_TICK;
		it.reg_addr = 8'($urandom_range(0, 255));
		it.byte_count = 8'($urandom_range(0, 255));
		it.wr_index = 4'($urandom_range(0, 15));
		it.wr_byte = 8'($urandom_range(0, 255));
		it.sda = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Next item while a transfer runs; the slave answers on SDA by the model's phase.
	function automatic stim_t next_tick();
		stim_t it;
		int pick;
		it = rand_item();
		if (plan_noise) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) it.req = REQ_LOAD;
			else if (pick < 15) it.req = ($urandom_range(0, 1) != 0) ? REQ_START_W : REQ_START_R;
		end
		if (ph == PH_TXACK_LO) begin
			pick = $urandom_range(0, 99);
			if (acks_seen == plan_nack) ack_hold = int'(ack_limit) + 1;
			else if (plan_slow || pick < 7) ack_hold = int'(ack_limit);
			else if (pick < 75) ack_hold = 0;
			else if (pick < 92) ack_hold = $urandom_range(1, 3);
			else ack_hold = $urandom_range(0, int'(ack_limit));
			acks_seen++;
		end else if (ph == PH_TXACK_HI) begin
			it.sda = (ack_hold > 0);
			if (ack_hold > 0) ack_hold--;
		end
		return it;
	endfunction

	function automatic row_t row(input req_t req, input logic [7:0] reg_addr, cnt,
		input logic [3:0] idx, input logic [7:0] wbyte, input logic sda,
		input int nack_at, input bit slow, noise, input int exp_kind);
		row_t rw;
		rw.is_cfg = 1'b0;
		rw.cfg_addr = 7'd0;
		rw.cfg_limit = 8'd0;
		rw.item = '{req: req, reg_addr: reg_addr, byte_count: cnt, wr_index: idx,
			wr_byte: wbyte, sda: sda};
		rw.nack_at = nack_at;
		rw.slow = slow;
		rw.noise = noise;
		rw.exp_kind = exp_kind;
		return rw;
	endfunction

	function automatic row_t cfg_row(input logic [6:0] addr, input logic [7:0] limit);
		row_t rw;
		rw = row(REQ_TICK, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, NO_NACK, 1'b0, 1'b0, EXP_PRED);
		rw.is_cfg = 1'b1;
		rw.cfg_addr = addr;
		rw.cfg_limit = limit;
		return rw;
	endfunction

	// Random row: mostly short well-formed transfers, some idle ticks and buffer loads.
	function automatic row_t rand_row();
		row_t rw;
		int pick, acks;
		rw = row(REQ_TICK, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, NO_NACK, 1'b0,
			1'($urandom_range(0, 1)), EXP_PRED);
		rw.item = rand_item();
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			rw.item.req = (pick < 10) ? REQ_TICK : REQ_LOAD;
		end else begin
			if (pick < 60) begin
				rw.item.req = REQ_START_W;
				rw.item.byte_count = ($urandom_range(0, 99) < 80) ?
					8'($urandom_range(0, 4)) : 8'($urandom_range(5, 8));
				acks = 2 + int'(rw.item.byte_count);
			end else begin
				rw.item.req = REQ_START_R;
				rw.item.byte_count = ($urandom_range(0, 99) < 80) ?
					8'($urandom_range(0, 3)) : 8'($urandom_range(4, 6));
				acks = 3;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) rw.nack_at = $urandom_range(0, acks - 1);
			else if (pick < 25) rw.slow = 1'b1;
		end
		return rw;
	endfunction

	// Offer one item with a random lead-in gap; predict its result once it is taken.
	task automatic send_item(input stim_t it, input int exp_kind);
		bus_res_t r;
		int gap, pick;
		pick = $urandom_range(0, 99);
		if (src_quiet || pick < 65) gap = 0;
		else if (pick < 93) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.req;
		s_tdata <= {3'b000, it.sda, it.wr_byte, it.wr_index, it.byte_count, it.reg_addr};
		do @(posedge clk); while (!s_tready);
		r = bus_tick(it);
		if (r.done && r.failed) n_failed_xfers++;
		if (r.rd_valid) n_rd_bytes++;
		case (exp_kind)
			EXP_IDLE: pending_bus_q.push_back(IDLE_RES);
			EXP_START: pending_bus_q.push_back(START_RES);
			default: pending_bus_q.push_back(r);
		endcase
		n_items++;
	endtask

	// Stop offering items and wait until every result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_bus_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SLAVE_ADDRESS) dev_addr = val[6:0];
		else ack_limit = val;
		n_cfg_writes++;
	endtask

	// Apply a row; a started transfer is ticked through to its STOP.
	task automatic play_row(input row_t rw);
		if (rw.is_cfg) begin
			drain();
			write_reg(CFG_SLAVE_ADDRESS, {1'b0, rw.cfg_addr});
			write_reg(CFG_ACK_TIMEOUT, rw.cfg_limit);
		end else begin
			plan_nack = rw.nack_at;
			plan_slow = rw.slow;
			plan_noise = rw.noise;
			acks_seen = 0;
			src_quiet = ($urandom_range(0, 4) == 0);
			send_item(rw.item, rw.exp_kind);
			while (ph != PH_IDLE) send_item(next_tick(), EXP_PRED);
		end
	endtask

	// Directed table.
	task automatic build_table();
		// Idle bus with every field at its low end, then at its high end.
		dir_rows.push_back(row(REQ_TICK, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, NO_NACK, 0, 0, EXP_IDLE));
		dir_rows.push_back(row(REQ_TICK, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, NO_NACK, 0, 0, EXP_IDLE));
		// First and last buffer slots with the extreme bytes.
		dir_rows.push_back(row(REQ_LOAD, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, NO_NACK, 0, 0, EXP_IDLE));
		dir_rows.push_back(row(REQ_LOAD, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, NO_NACK, 0, 0, EXP_IDLE));
		// Write with no data bytes at the reset settings; its first START phase shows at once.
		dir_rows.push_back(row(REQ_START_W, 8'h3C, 8'h00, 4'h0, 8'h00, 1'b0, NO_NACK, 0, 0,
			EXP_START));
		// A short timeout keeps the remaining transfers brief.
		dir_rows.push_back(cfg_row(7'h2A, 8'd3));
		// Write count above the buffer depth, with requests mixed in while busy.
		dir_rows.push_back(row(REQ_START_W, 8'hFF, 8'hFF, 4'h0, 8'h00, 1'b1, NO_NACK, 0, 1,
			EXP_PRED));
		// Two-byte read: an acknowledged byte, then the final byte with a NACK.
		dir_rows.push_back(row(REQ_START_R, 8'hA5, 8'h02, 4'h0, 8'h00, 1'b0, NO_NACK, 0, 1,
			EXP_START));
		// Read with no data bytes whose address+R ACK times out without failing.
		dir_rows.push_back(row(REQ_START_R, 8'h81, 8'h00, 4'h0, 8'h00, 1'b0, 2, 0, 0, EXP_PRED));
		// Missing ACK on the second data byte.
		dir_rows.push_back(row(REQ_START_W, 8'h20, 8'h02, 4'h0, 8'h00, 1'b0, 3, 0, 0, EXP_PRED));
		// Shortest timeout: the address ACK comes on the last tolerated sample, and the
		// register ACK comes one sample too late, which does not fail the write.
		dir_rows.push_back(cfg_row(7'h7F, 8'd1));
		dir_rows.push_back(row(REQ_START_W, 8'h55, 8'h00, 4'h0, 8'h00, 1'b0, 1, 1, 0, EXP_PRED));
		// Missing address ACK on a read.
		dir_rows.push_back(row(REQ_START_R, 8'h55, 8'h02, 4'h0, 8'h00, 1'b0, 0, 0, 0, EXP_PRED));
	endtask

	// Result checker.
	always @(posedge clk) begin
		bus_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.scl = m_tdata[0];
			got.sda = m_tdata[1];
			got.drive = m_tdata[2];
			got.busy = m_tdata[3];
			got.rd_data = m_tdata[11:4];
			got.rd_valid = m_tdata[12];
			got.rd_last = m_tlast;
			got.done = m_tdata[13];
			got.failed = m_tdata[14];
			if (pending_bus_q.size() == 0) begin
				if (n_err < MAX_REPORTS) $display("%0t: result with none expected: %s", $realtime,
					show(got));
				n_err++;
			end else begin
				want = pending_bus_q.pop_front();
				n_checked++;
				if (got !== want) begin
					if (n_err < MAX_REPORTS) begin
						$display("%0t: result %0d differs", $realtime, n_checked);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
					n_err++;
				end
			end
		end
	end

	// Receiver stalls: mostly short, a few long, with quiet stretches.
	always @(posedge clk) begin
		if (sink_wait != 0) begin
			m_tready <= 1'b0;
			sink_wait <= sink_wait - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 299) == 0) sink_quiet <= !sink_quiet;
			if (!sink_quiet && $urandom_range(0, 99) < 20) begin
				sink_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 2);
			end
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence.
	initial begin
		int rand_base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every buffer slot before any write can read one.
		for (int i = 0; i < MAX_WRITE_BYTES; i++) begin
			stim_t it;
			it = rand_item();
			it.req = REQ_LOAD;
			it.wr_index = 4'(i);
			send_item(it, EXP_IDLE);
		end

		build_table();
		foreach (dir_rows[i]) play_row(dir_rows[i]);

		// Random transfers under two short-timeout settings.
		rand_base = n_items;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: play_row(cfg_row(7'($urandom_range(0, 127)), 8'($urandom_range(2, 8))));
				default: play_row(cfg_row(7'($urandom_range(0, 127)), 8'd1));
			endcase
			while (n_items - rand_base < (p + 1) * RAND_ITEMS / RAND_PHASES) play_row(rand_row());
		end

		drain();
		$display("Checked %0d results from %0d items over %0d transfers and %0d register writes.",
			n_checked, n_items, n_xfers, n_cfg_writes);
		$display("Transfers failed on a missing ACK: %0d; bytes read: %0d; mismatches: %0d.",
			n_failed_xfers, n_rd_bytes, n_err);
		if (n_err == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> i2c_register_access_master_top.f
design/i2cram_pkg.sv
design/i2cram_step.sv
design/i2c_register_access_master_top.sv
tb/tb.sv
